/* rtl/ordered_list_insert_delete_macros.svh */
// Assertion macros for the ordered list block
`ifndef ORDERED_LIST_INSERT_DELETE_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define OLID_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset
`define OLID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/olid_pkg.sv */
// Shared types and constants for the ordered list block
`default_nettype none

package olid_pkg;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = 5;
  localparam int unsigned DW    = 32;

  typedef enum logic [1:0] {
    ModeInsert = 2'd0,
    ModeDelete = 2'd1,
    ModeRead   = 2'd2,
    ModeAppend = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatRange = 2'd1,
    StatFull  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StRdWait = 4'b0010,
    StShift  = 4'b0100,
    StDone   = 4'b1000
  } state_e;

  typedef struct packed {
    logic signed [DW-1:0] data;
    logic [CW-1:0]        moved;
    status_e              status;
    logic [CW-1:0]        size;
    logic                 empty;
    logic                 full;
  } res_t;

endpackage

`default_nettype wire

/* rtl/olid_ram.sv */
// Generic simple dual-port RAM with registered read
`default_nettype none

module olid_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/olid_ctrl.sv */
// Request sequencer: checks, shift walk over the list memory and count keeping
`default_nettype none

module olid_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         req_valid_i,
  output logic                              req_ready_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic [olid_pkg::CW-1:0]      position_i,
  input  wire logic signed [olid_pkg::DW-1:0] value_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output olid_pkg::res_t                    res_o,
  output logic                              mem_re_o,
  output logic [olid_pkg::AW-1:0]           mem_raddr_o,
  input  wire logic [olid_pkg::DW-1:0]      mem_rdata_i,
  output logic                              mem_we_o,
  output logic [olid_pkg::AW-1:0]           mem_waddr_o,
  output logic [olid_pkg::DW-1:0]           mem_wdata_o
);
  import olid_pkg::*;

  state_e               state_q, state_d;
  mode_e                mode_q, mode_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic signed [DW-1:0] val_q, val_d;
  logic [AW-1:0]        src_q, src_d;
  logic [AW-1:0]        dst_q, dst_d;
  logic [CW-1:0]        left_q, left_d;
  logic                 pend_q, pend_d;
  logic signed [DW-1:0] data_q, data_d;
  logic [CW-1:0]        moved_q, moved_d;
  status_e              status_q, status_d;
  mode_e                mode_in;
  logic                 is_full;

  assign mode_in = mode_e'(mode_i);
  assign is_full = (count_q == CW'(DEPTH));

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    count_d     = count_q;
    pos_d       = pos_q;
    val_d       = val_q;
    src_d       = src_q;
    dst_d       = dst_q;
    left_d      = left_q;
    pend_d      = pend_q;
    data_d      = data_q;
    moved_d     = moved_q;
    status_d    = status_q;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = position_i[AW-1:0];
    mem_we_o    = 1'b0;
    mem_waddr_o = count_q[AW-1:0];
    mem_wdata_o = value_i;

    case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          mode_d   = mode_in;
          pos_d    = position_i[AW-1:0];
          val_d    = value_i;
          pend_d   = 1'b0;
          data_d   = '0;
          moved_d  = '0;
          status_d = StatOk;
          state_d  = StDone;
          case (mode_in)
            ModeInsert: begin
              if (is_full) begin
                status_d = StatFull;
              end else if (position_i > count_q) begin
                status_d = StatRange;
              end else begin
                // walk downwards from the last entry, one move a cycle
                src_d   = AW'(count_q - CW'(1));
                dst_d   = count_q[AW-1:0];
                left_d  = count_q - position_i;
                moved_d = count_q - position_i;
                count_d = count_q + CW'(1);
                state_d = StShift;
              end
            end
            ModeDelete: begin
              if (position_i >= count_q) begin
                status_d = StatRange;
              end else begin
                mem_re_o = 1'b1;
                src_d    = AW'(position_i + CW'(1));
                dst_d    = position_i[AW-1:0];
                left_d   = count_q - CW'(1) - position_i;
                moved_d  = count_q - CW'(1) - position_i;
                count_d  = count_q - CW'(1);
                state_d  = StRdWait;
              end
            end
            ModeRead: begin
              if (position_i >= count_q) begin
                status_d = StatRange;
              end else begin
                mem_re_o = 1'b1;
                state_d  = StRdWait;
              end
            end
            ModeAppend: begin
              if (is_full) begin
                status_d = StatFull;
              end else begin
                mem_we_o = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            default: begin
              status_d = StatRange;
            end
          endcase
        end
      end
      StRdWait: begin
        data_d  = mem_rdata_i;
        state_d = (mode_q == ModeDelete) ? StShift : StDone;
      end
      StShift: begin
        // read one entry ahead, write the one read last cycle
        mem_re_o    = (left_q != '0);
        mem_raddr_o = src_q;
        if (mem_re_o) begin
          left_d = left_q - CW'(1);
          src_d  = (mode_q == ModeInsert) ? src_q - AW'(1) : src_q + AW'(1);
        end
        pend_d = mem_re_o;
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = dst_q;
          mem_wdata_o = mem_rdata_i;
          dst_d       = (mode_q == ModeInsert) ? dst_q - AW'(1) : dst_q + AW'(1);
        end else if (left_q == '0) begin
          if (mode_q == ModeInsert) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pos_q;
            mem_wdata_o = val_q;
          end
          state_d = StDone;
        end
      end
      StDone: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign res_o.data   = data_q;
  assign res_o.moved  = moved_q;
  assign res_o.status = status_q;
  assign res_o.size   = count_q;
  assign res_o.empty  = (count_q == '0);
  assign res_o.full   = is_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      left_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    data_q   <= data_d;
    moved_q  <= moved_d;
    status_q <= status_d;
  end

endmodule

`default_nettype wire

/* rtl/ordered_list_insert_delete.sv */
// Path to the result: append and rejected requests go straight to done, read waits
// on the memory read, insert walks the shift, delete waits on the read then shifts.
// Throughput: one request at a time; a shift moves one entry a cycle over the
// list memory's single read and single write port.
// Reset clears the count, the state, the shift bookkeeping and the output valid flag;
// list contents are not cleared. A result may wait in the output register while the next request is accepted.
`default_nettype none

module ordered_list_insert_delete (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [1:0]                   mode_i,
  input  wire logic [4:0]                   position_i,
  input  wire logic signed [31:0]           value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [31:0]                data_out_o,
  output logic [4:0]                        moved_o,
  output logic [1:0]                        status_o,
  output logic [4:0]                        list_size_o,
  output logic                              is_empty_flag_o,
  output logic                              is_full_flag_o
);
  import olid_pkg::*;

  `include "ordered_list_insert_delete_macros.svh"

  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          out_q;
  logic          out_valid_q;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  olid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .mode_i      (mode_i),
    .position_i  (position_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata)
  );

  olid_ram #(
    .Width (DW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign data_out_o      = out_q.data;
  assign moved_o         = out_q.moved;
  assign status_o        = out_q.status;
  assign list_size_o     = out_q.size;
  assign is_empty_flag_o = out_q.empty;
  assign is_full_flag_o  = out_q.full;

  `OLID_ASSERT_SAME(a_reject_clean, out_valid_o && (status_o != StatOk), (moved_o == '0) && (data_out_o == '0), "rejected request moved or returned data")
  `OLID_ASSERT_SAME(a_flags_match, out_valid_o, (is_empty_flag_o == (list_size_o == '0)) && (is_full_flag_o == (list_size_o == CW'(DEPTH))), "empty or full flag disagrees with size")
  `OLID_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_o, !in_ready_o, "request accepted while previous one in flight")
  `OLID_ASSERT_NEXT(a_res_held, res_valid && !res_ready, res_valid && $stable(res), "pending result dropped or changed")

endmodule

`default_nettype wire
